// ===== rtl/gaps_pkg.sv =====
package gaps_pkg;

	// Default sizes of the grid and the path store
	localparam int MAX_DIM_DEF  = 32;
	localparam int MAX_PATH_DEF = 1024;

	// Tile byte that marks a cell as blocked even though nonzero
	localparam logic [7:0] BLOCKED_TILE_CODE = 8'd255;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'b1;
	localparam logic [CFG_DATA_W-1:0] MAP_DIM_RESET = 6'd32;

	// Operation codes
	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_PATH = 2'd1;
	localparam logic [1:0] ST_BLOCKED = 2'd2;
	localparam logic [1:0] ST_BAD_IDX = 2'd3;

	// Neighbor directions in scan order
	localparam logic [2:0] DIR_N  = 3'd0;
	localparam logic [2:0] DIR_S  = 3'd1;
	localparam logic [2:0] DIR_E  = 3'd2;
	localparam logic [2:0] DIR_W  = 3'd3;
	localparam logic [2:0] DIR_NW = 3'd4;
	localparam logic [2:0] DIR_NE = 3'd5;
	localparam logic [2:0] DIR_SW = 3'd6;
	localparam logic [2:0] DIR_SE = 3'd7;

	typedef struct packed {
		logic [1:0] operation;
		logic [4:0] col;
		logic [4:0] row;
		logic [7:0] tile;
		logic [4:0] goal_col;
		logic [4:0] goal_row;
		logic [9:0] path_index;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [10:0] path_length;
		logic [4:0]  out_col;
		logic [4:0]  out_row;
	} out_item_t;

	// Unit step of one direction (north is row + 1)
	typedef struct packed {
		logic c_inc;
		logic c_dec;
		logic r_inc;
		logic r_dec;
	} step_t;

	function automatic step_t dir_step(input logic [2:0] dir);
		step_t s;
		s = '0;
		unique case (dir)
			DIR_N:  s.r_inc = 1'b1;
			DIR_S:  s.r_dec = 1'b1;
			DIR_E:  s.c_inc = 1'b1;
			DIR_W:  s.c_dec = 1'b1;
			DIR_NW: begin s.c_dec = 1'b1; s.r_inc = 1'b1; end
			DIR_NE: begin s.c_inc = 1'b1; s.r_inc = 1'b1; end
			DIR_SW: begin s.c_dec = 1'b1; s.r_dec = 1'b1; end
			DIR_SE: begin s.c_inc = 1'b1; s.r_dec = 1'b1; end
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/grid_astar_path_search_core.sv =====
// Tile write and unknown operation: result registered in the cycle after the item is taken;
// path read: result through state S_RD. Search: checks start and goal, clears the flags of
// all cells, scans the map and visits 8 neighbors per expansion, then traces the path.
// One item at a time; the next item is taken once the result slot is free.
// Reset: asynchronous, active low; afterwards all MAX_DIM * MAX_DIM cells of the walkability
// store are wiped, one cell per cycle, while input is stalled (config writes still taken).
module grid_astar_path_search_core
	import gaps_pkg::*;
#(
	parameter int MAX_DIM  = MAX_DIM_DEF,
	parameter int MAX_PATH = MAX_PATH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CELLS = MAX_DIM * MAX_DIM;
	localparam int CW    = $clog2(MAX_DIM);
	localparam int DW    = $clog2(MAX_DIM + 1);
	localparam int AW    = $clog2(CELLS);
	localparam int GW    = AW + 1;
	localparam int SW    = AW + 1;
	localparam int FW    = AW + 2;
	localparam int PW    = $clog2(MAX_PATH);
	localparam int KW    = $clog2(MAX_PATH + 1);
	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

	typedef struct packed {
		logic is_open;
		logic is_closed;
	} flag_t;

	typedef struct packed {
		logic [GW-1:0] g;
		logic [2:0]    pdir;
		logic [SW-1:0] stamp;
	} node_t;

	typedef struct packed {
		logic [CW-1:0] r;
		logic [CW-1:0] c;
	} coord_t;

	typedef enum logic [13:0] {
		S_WIPE  = 14'b00000000000001,
		S_IDLE  = 14'b00000000000010,
		S_CHK_S = 14'b00000000000100,
		S_CHK_G = 14'b00000000001000,
		S_CHK_E = 14'b00000000010000,
		S_CLR   = 14'b00000000100000,
		S_INIT  = 14'b00000001000000,
		S_SCAN  = 14'b00000010000000,
		S_EXP   = 14'b00000100000000,
		S_NB_RD = 14'b00001000000000,
		S_NB_WR = 14'b00010000000000,
		S_TR_RD = 14'b00100000000000,
		S_TR_WR = 14'b01000000000000,
		S_RD    = 14'b10000000000000
	} state_t;

	function automatic logic [AW-1:0] cell_of(input logic [CW-1:0] c, input logic [CW-1:0] r);
		return AW'(r * MAX_DIM + c);
	endfunction

	function automatic logic [CW:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
		return (a > b) ? {1'b0, a - b} : {1'b0, b - a};
	endfunction

	// Memories
	logic  walk_mem [CELLS];
	flag_t flag_mem [CELLS];
	node_t node_mem [CELLS];
	coord_t path_mem [MAX_PATH];

	logic   walk_rq;
	flag_t  flag_rq;
	node_t  node_rq;
	coord_t path_rq;

	logic [AW-1:0] rd_addr;
	logic          walk_we, walk_wd;
	logic [AW-1:0] walk_wa;
	logic          flag_we;
	logic [AW-1:0] flag_wa;
	flag_t         flag_wd;
	logic          node_we;
	logic [AW-1:0] node_wa;
	node_t         node_wd;
	logic          path_we;
	logic [PW-1:0] path_wa;
	logic [PW-1:0] path_ra;

	// Control and working registers
	state_t state_q, state_d;
	logic [AW-1:0] clr_q;
	logic [CFG_DATA_W-1:0] width_q, height_q;
	logic [CW-1:0] sc_q, sr_q, gc_q, gr_q;
	logic start_in_q, goal_in_q, start_ok_q, rd_ok_q;
	logic [SW-1:0] stamp_q;
	logic [2:0] dir_q;
	logic nvalid_q;
	logic [AW-1:0] ncell_q;
	logic scan_run_q;
	logic [CW-1:0] scol_q, srow_q;
	logic val_s1;
	logic [CW-1:0] col_s1, row_s1;
	logic [CW:0] h_s1;
	logic found_q;
	logic [FW-1:0] bf_q;
	logic [SW-1:0] bs_q;
	logic [CW-1:0] bc_q, br_q;
	logic [GW-1:0] bg_q;
	logic [KW-1:0] k_q, len_q, stored_len_q;
	logic [CW-1:0] pc_q, pr_q;
	logic out_valid_q;
	out_item_t res_q;

	// Combinational helpers
	logic in_acc;
	logic [DW-1:0] w_eff, h_eff;
	logic res_load;
	out_item_t res_d;
	logic scan_start;
	step_t nstep, tstep;
	logic [CW:0] ncx, nrx;
	logic n_ok;
	logic [FW-1:0] f_s1;
	logic better;
	logic [GW-1:0] ng;
	logic best_is_goal;
	logic path_fits;

	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = res_q;

	// Registers above MAX_DIM act as MAX_DIM
	assign w_eff = (32'(width_q) > 32'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(width_q);
	assign h_eff = (32'(height_q) > 32'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(height_q);

	// Neighbor of the best cell in direction dir_q
	assign nstep = dir_step(dir_q);
	assign ncx = nstep.c_inc ? {1'b0, bc_q} + 1'b1 :
		nstep.c_dec ? {1'b0, bc_q} - 1'b1 : {1'b0, bc_q};
	assign nrx = nstep.r_inc ? {1'b0, br_q} + 1'b1 :
		nstep.r_dec ? {1'b0, br_q} - 1'b1 : {1'b0, br_q};
	assign n_ok = !ncx[CW] && !nrx[CW] && (32'(ncx) < 32'(w_eff)) && (32'(nrx) < 32'(h_eff));

	// Back-step along the parent direction during trace
	assign tstep = dir_step(node_rq.pdir);

	// Score of the scanned cell and tie rule (newer insert wins)
	assign f_s1   = FW'(node_rq.g) + FW'(h_s1);
	assign better = !found_q || (f_s1 < bf_q) || ((f_s1 == bf_q) && (node_rq.stamp > bs_q));
	assign ng     = bg_q + 1'b1;
	assign best_is_goal = (bc_q == gc_q) && (br_q == gr_q);
	assign path_fits    = (32'(bg_q) + 32'd1) <= 32'(MAX_PATH);
	assign path_ra      = PW'(in_data.path_index);

	// Sequencer and memory port control
	always_comb begin
		state_d    = state_q;
		rd_addr    = '0;
		walk_we    = 1'b0;
		walk_wa    = clr_q;
		walk_wd    = 1'b0;
		flag_we    = 1'b0;
		flag_wa    = clr_q;
		flag_wd    = '0;
		node_we    = 1'b0;
		node_wa    = ncell_q;
		node_wd    = '0;
		path_we    = 1'b0;
		path_wa    = PW'(k_q - 1'b1);
		res_load   = 1'b0;
		res_d      = '{status: ST_OK, path_length: 11'(stored_len_q), out_col: '0, out_row: '0};
		scan_start = 1'b0;
		unique case (state_q)
			S_WIPE: begin
				walk_we = 1'b1;
				if (clr_q == LAST_CELL) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_acc) begin
					unique case (in_data.operation)
						OP_WRITE: begin
							res_load = 1'b1;
							if (32'(in_data.col) < 32'(MAX_DIM) &&
								32'(in_data.row) < 32'(MAX_DIM)) begin
								walk_we = 1'b1;
								walk_wa = cell_of(CW'(in_data.col), CW'(in_data.row));
								walk_wd = (in_data.tile != 8'd0) &&
									(in_data.tile != BLOCKED_TILE_CODE);
							end
						end
						OP_SEARCH: state_d = S_CHK_S;
						OP_READ:   state_d = S_RD;
						default:   res_load = 1'b1;
					endcase
				end
			end
			S_CHK_S: begin
				rd_addr = cell_of(sc_q, sr_q);
				state_d = S_CHK_G;
			end
			S_CHK_G: begin
				rd_addr = cell_of(gc_q, gr_q);
				state_d = S_CHK_E;
			end
			S_CHK_E: begin
				if (start_ok_q && goal_in_q && walk_rq) begin
					state_d = S_CLR;
				end else begin
					res_load     = 1'b1;
					res_d.status = ST_BLOCKED;
					state_d      = S_IDLE;
				end
			end
			S_CLR: begin
				flag_we = 1'b1;
				if (clr_q == LAST_CELL) state_d = S_INIT;
			end
			S_INIT: begin
				// Start cell enters the open set with g = 0 and stamp 0
				flag_we    = 1'b1;
				flag_wa    = cell_of(sc_q, sr_q);
				flag_wd    = '{is_open: 1'b1, is_closed: 1'b0};
				node_we    = 1'b1;
				node_wa    = cell_of(sc_q, sr_q);
				scan_start = 1'b1;
				state_d    = S_SCAN;
			end
			S_SCAN: begin
				rd_addr = cell_of(scol_q, srow_q);
				if (!scan_run_q && !val_s1) begin
					if (found_q) begin
						state_d = S_EXP;
					end else begin
						res_load     = 1'b1;
						res_d.status = ST_NO_PATH;
						state_d      = S_IDLE;
					end
				end
			end
			S_EXP: begin
				flag_we = 1'b1;
				flag_wa = cell_of(bc_q, br_q);
				flag_wd = '{is_open: 1'b0, is_closed: 1'b1};
				if (!best_is_goal) begin
					state_d = S_NB_RD;
				end else if (path_fits) begin
					state_d = S_TR_RD;
				end else begin
					res_load     = 1'b1;
					res_d.status = ST_NO_PATH;
					state_d      = S_IDLE;
				end
			end
			S_NB_RD: begin
				rd_addr = cell_of(CW'(ncx), CW'(nrx));
				state_d = S_NB_WR;
			end
			S_NB_WR: begin
				if (nvalid_q && walk_rq && !flag_rq.is_closed) begin
					if (flag_rq.is_open) begin
						// Better route: new g and parent, stamp kept
						if (ng < node_rq.g) begin
							node_we = 1'b1;
							node_wd = '{g: ng, pdir: dir_q, stamp: node_rq.stamp};
						end
					end else begin
						flag_we = 1'b1;
						flag_wa = ncell_q;
						flag_wd = '{is_open: 1'b1, is_closed: 1'b0};
						node_we = 1'b1;
						node_wd = '{g: ng, pdir: dir_q, stamp: stamp_q};
					end
				end
				if (dir_q == DIR_SE) begin
					scan_start = 1'b1;
					state_d    = S_SCAN;
				end else begin
					state_d = S_NB_RD;
				end
			end
			S_TR_RD: begin
				path_we = 1'b1;
				rd_addr = cell_of(pc_q, pr_q);
				if (k_q == KW'(1)) begin
					res_load          = 1'b1;
					res_d.path_length = 11'(len_q);
					state_d           = S_IDLE;
				end else begin
					state_d = S_TR_WR;
				end
			end
			S_TR_WR: state_d = S_TR_RD;
			S_RD: begin
				res_load = 1'b1;
				if (rd_ok_q) begin
					res_d.out_col = 5'(path_rq.c);
					res_d.out_row = 5'(path_rq.r);
				end else begin
					res_d.status = ST_BAD_IDX;
				end
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Memory ports: one write and one registered read each
	always_ff @(posedge clk) begin
		if (walk_we) walk_mem[walk_wa] <= walk_wd;
		if (flag_we) flag_mem[flag_wa] <= flag_wd;
		if (node_we) node_mem[node_wa] <= node_wd;
		if (path_we) path_mem[path_wa] <= '{r: pr_q, c: pc_q};
		walk_rq <= walk_mem[rd_addr];
		flag_rq <= flag_mem[rd_addr];
		node_rq <= node_mem[rd_addr];
		path_rq <= path_mem[path_ra];
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_WIPE;
			clr_q        <= '0;
			width_q      <= MAP_DIM_RESET;
			height_q     <= MAP_DIM_RESET;
			sc_q         <= '0;
			sr_q         <= '0;
			gc_q         <= '0;
			gr_q         <= '0;
			start_in_q   <= 1'b0;
			goal_in_q    <= 1'b0;
			start_ok_q   <= 1'b0;
			rd_ok_q      <= 1'b0;
			stamp_q      <= '0;
			dir_q        <= DIR_N;
			nvalid_q     <= 1'b0;
			ncell_q      <= '0;
			scan_run_q   <= 1'b0;
			scol_q       <= '0;
			srow_q       <= '0;
			val_s1       <= 1'b0;
			col_s1       <= '0;
			row_s1       <= '0;
			h_s1         <= '0;
			found_q      <= 1'b0;
			bf_q         <= '0;
			bs_q         <= '0;
			bc_q         <= '0;
			br_q         <= '0;
			bg_q         <= '0;
			k_q          <= '0;
			len_q        <= '0;
			stored_len_q <= '0;
			pc_q         <= '0;
			pr_q         <= '0;
			out_valid_q  <= 1'b0;
			res_q        <= '0;
		end else begin
			state_q <= state_d;

			// Configuration writes
			if (cfg_write) begin
				if (cfg_index == REG_MAP_WIDTH) width_q <= cfg_data;
				if (cfg_index == REG_MAP_HEIGHT) height_q <= cfg_data;
			end

			// Sweep counter for wipe and flag clear
			if (state_q == S_WIPE || state_q == S_CLR) begin
				clr_q <= (clr_q == LAST_CELL) ? '0 : clr_q + 1'b1;
			end

			// Item capture
			if (in_acc) begin
				sc_q       <= CW'(in_data.col);
				sr_q       <= CW'(in_data.row);
				gc_q       <= CW'(in_data.goal_col);
				gr_q       <= CW'(in_data.goal_row);
				start_in_q <= (32'(in_data.col) < 32'(w_eff)) && (32'(in_data.row) < 32'(h_eff));
				goal_in_q  <= (32'(in_data.goal_col) < 32'(w_eff)) &&
					(32'(in_data.goal_row) < 32'(h_eff));
				rd_ok_q    <= 32'(in_data.path_index) < 32'(stored_len_q);
				if (in_data.operation == OP_SEARCH) stored_len_q <= '0;
			end

			if (state_q == S_CHK_G) start_ok_q <= start_in_q && walk_rq;

			// Insert stamps
			if (state_q == S_INIT) begin
				stamp_q <= SW'(1);
			end else if (state_q == S_NB_WR && nvalid_q && walk_rq &&
				!flag_rq.is_closed && !flag_rq.is_open) begin
				stamp_q <= stamp_q + 1'b1;
			end

			// Neighbor walk
			if (state_q == S_EXP) dir_q <= DIR_N;
			if (state_q == S_NB_WR) dir_q <= dir_q + 1'b1;
			if (state_q == S_NB_RD) begin
				nvalid_q <= n_ok;
				ncell_q  <= cell_of(CW'(ncx), CW'(nrx));
			end

			// Min-score scan over the map, one cell per cycle
			if (scan_start) begin
				scan_run_q <= 1'b1;
				scol_q     <= '0;
				srow_q     <= '0;
				val_s1     <= 1'b0;
				found_q    <= 1'b0;
			end else if (state_q == S_SCAN) begin
				val_s1 <= scan_run_q;
				if (scan_run_q) begin
					col_s1 <= scol_q;
					row_s1 <= srow_q;
					h_s1   <= abs_diff(scol_q, gc_q) + abs_diff(srow_q, gr_q);
					if (32'(scol_q) + 32'd1 >= 32'(w_eff)) begin
						scol_q <= '0;
						if (32'(srow_q) + 32'd1 >= 32'(h_eff)) begin
							scan_run_q <= 1'b0;
						end else begin
							srow_q <= srow_q + 1'b1;
						end
					end else begin
						scol_q <= scol_q + 1'b1;
					end
				end
				if (val_s1 && flag_rq.is_open && better) begin
					found_q <= 1'b1;
					bf_q    <= f_s1;
					bs_q    <= node_rq.stamp;
					bc_q    <= col_s1;
					br_q    <= row_s1;
					bg_q    <= node_rq.g;
				end
			end

			// Path trace from goal back to start
			if (state_q == S_EXP) begin
				k_q   <= KW'(ng);
				len_q <= KW'(ng);
				pc_q  <= bc_q;
				pr_q  <= br_q;
			end
			if (state_q == S_TR_RD && k_q == KW'(1)) stored_len_q <= len_q;
			if (state_q == S_TR_WR) begin
				k_q  <= k_q - 1'b1;
				pc_q <= tstep.c_inc ? pc_q - 1'b1 : tstep.c_dec ? pc_q + 1'b1 : pc_q;
				pr_q <= tstep.r_inc ? pr_q - 1'b1 : tstep.r_dec ? pr_q + 1'b1 : pr_q;
			end

			// Output register
			if (res_load) begin
				out_valid_q <= 1'b1;
				res_q       <= res_d;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_res_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> !(out_valid_q && out_stall))
		else $error("result loaded over a pending item");

	a_scan_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		val_s1 |-> (state_q == S_SCAN))
		else $error("scan pipeline active outside scan");

	a_path_len: assert property (@(posedge clk) disable iff (!arst_n)
		32'(stored_len_q) <= 32'(MAX_PATH))
		else $error("stored path longer than store");

	a_trace_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TR_RD || state_q == S_TR_WR) |-> (k_q != '0))
		else $error("trace counter ran out");

	a_expand_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXP) |-> found_q)
		else $error("expansion without an open cell");
`endif

endmodule

// ===== verif/grid_astar_path_search_core_tb.sv =====
module grid_astar_path_search_core_tb;
	import gaps_pkg::*;

	localparam int GRID = 32;
	localparam int CYCLE_LIMIT = 20000000;
	// Operation code with no meaning; the block answers it with no change of state
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Path search scoreboard: keeps its own grid, searches it and queues the expected results
	class path_scoreboard;
		bit        walk[GRID*GRID];
		int        gcost[GRID*GRID];
		int        stamp[GRID*GRID];
		bit        open_set[GRID*GRID];
		bit        closed_set[GRID*GRID];
		bit [2:0]  came_from[GRID*GRID];
		int        path_cell[GRID*GRID];
		int        stored_len;
		int        map_w;
		int        map_h;
		int        dcol[8];
		int        drow[8];
		out_item_t expected_q[$];
		int        errors;

		function new();
			dcol = '{0, 0, 1, -1, -1, 1, -1, 1};
			drow = '{1, -1, 0, 0, 1, 1, -1, -1};
			map_w = MAP_DIM_RESET;
			map_h = MAP_DIM_RESET;
			stored_len = 0;
			errors = 0;
			foreach (walk[i]) walk[i] = 0;
		endfunction

		// registers keep only their low 6 bits
		function void set_reg(logic [CFG_IDX_W-1:0] idx, int val);
			if (idx == REG_MAP_WIDTH) map_w = val & 63;
			else map_h = val & 63;
		endfunction

		function int eff_w();
			return map_w > GRID ? GRID : map_w;
		endfunction

		function int eff_h();
			return map_h > GRID ? GRID : map_h;
		endfunction

		function bit cell_ok(int c, int r);
			if (c < 0 || r < 0 || c >= eff_w() || r >= eff_h()) return 0;
			return walk[r*GRID + c];
		endfunction

		// A* with Manhattan estimate; ties go to the newest open cell
		function logic [1:0] find_path(int sc, int sr, int gc, int gr);
			int cnt, best, bc, br, bf, bs, f, idx, nc, nr, ni, ng, len, pc, pr, k, d, s;
			cnt = 0;
			stored_len = 0;
			if (!cell_ok(sc, sr) || !cell_ok(gc, gr)) return ST_BLOCKED;
			foreach (open_set[i]) begin
				open_set[i] = 0;
				closed_set[i] = 0;
			end
			s = sr*GRID + sc;
			open_set[s] = 1;
			gcost[s] = 0;
			came_from[s] = DIR_N;
			stamp[s] = cnt++;
			forever begin
				best = -1;
				bc = 0; br = 0; bf = 0; bs = 0;
				for (int r = 0; r < eff_h(); r++) begin
					for (int c = 0; c < eff_w(); c++) begin
						idx = r*GRID + c;
						if (!open_set[idx]) continue;
						f = gcost[idx] + (c > gc ? c - gc : gc - c) + (r > gr ? r - gr : gr - r);
						if (best < 0 || f < bf || (f == bf && stamp[idx] > bs)) begin
							best = idx; bf = f; bs = stamp[idx]; bc = c; br = r;
						end
					end
				end
				if (best < 0) return ST_NO_PATH;
				open_set[best] = 0;
				closed_set[best] = 1;
				if (bc == gc && br == gr) begin
					len = gcost[best] + 1;
					if (len > MAX_PATH_DEF) return ST_NO_PATH;
					pc = bc;
					pr = br;
					for (k = len; k > 0; k--) begin
						path_cell[k-1] = pr*GRID + pc;
						if (k > 1) begin
							d = came_from[pr*GRID + pc];
							pc -= dcol[d];
							pr -= drow[d];
							if (pc < 0 || pr < 0 || pc >= GRID || pr >= GRID) return ST_NO_PATH;
						end
					end
					stored_len = len;
					return ST_OK;
				end
				// relax neighbors in scan order
				for (d = 0; d < 8; d++) begin
					nc = bc + dcol[d];
					nr = br + drow[d];
					if (!cell_ok(nc, nr)) continue;
					ni = nr*GRID + nc;
					if (closed_set[ni]) continue;
					ng = gcost[best] + 1;
					if (open_set[ni]) begin
						if (ng < gcost[ni]) begin
							gcost[ni] = ng;
							came_from[ni] = 3'(d);
						end
					end else begin
						open_set[ni] = 1;
						gcost[ni] = ng;
						came_from[ni] = 3'(d);
						stamp[ni] = cnt++;
					end
				end
			end
		endfunction

		function void note_item(in_item_t it);
			out_item_t e;
			e = '0;
			case (it.operation)
				OP_WRITE: walk[it.row*GRID + it.col] = it.tile != 8'd0 &&
					it.tile != BLOCKED_TILE_CODE;
				OP_SEARCH: e.status = find_path(it.col, it.row, it.goal_col, it.goal_row);
				OP_READ: begin
					if (it.path_index < stored_len) begin
						e.out_col = 5'(path_cell[it.path_index] % GRID);
						e.out_row = 5'(path_cell[it.path_index] / GRID);
					end else begin
						e.status = ST_BAD_IDX;
					end
				end
				default: ;
			endcase
			e.path_length = stored_len[10:0];
			expected_q.push_back(e);
		endfunction

		function void check_result(out_item_t got);
			out_item_t e;
			if (expected_q.size() == 0) begin
				$error("result with nothing expected: %h", got);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, got.status);
				errors++;
			end
			if (got.path_length !== e.path_length) begin
				$error("path_length: expected %0d, got %0d", e.path_length, got.path_length);
				errors++;
			end
			if (got.out_col !== e.out_col) begin
				$error("out_col: expected %0d, got %0d", e.out_col, got.out_col);
				errors++;
			end
			if (got.out_row !== e.out_row) begin
				$error("out_row: expected %0d, got %0d", e.out_row, got.out_row);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_item_t             out_data;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	path_scoreboard sb;
	bit tx_busy;
	bit rx_busy;
	bit long_hold;
	int big_map;

	grid_astar_path_search_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Watchdog
	initial begin
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("grid_astar_path_search_core_tb: done, errors");
				$finish;
			end
		end
	end

	// Result side: random stalls, and one long hold-off when long_hold is set
	initial begin
		int n;
		out_stall = 1'b1;
		wait (arst_n === 1'b1);
		forever begin
			n = rx_busy ? $urandom_range(0, 12) : 0;
			if (long_hold) begin
				n = 400;
				long_hold = 0;
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			sb.check_result(out_data);
		end
	end

	task automatic send_item(in_item_t it);
		int gap;
		gap = tx_busy ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		sb.note_item(it);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_q.size() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_write <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	function automatic in_item_t make_item(logic [1:0] op, int c, int r, int t, int gc, int gr,
		int pidx);
		in_item_t it;
		it = '0;
		it.operation = op;
		it.col = 5'(c);
		it.row = 5'(r);
		it.tile = 8'(t);
		it.goal_col = 5'(gc);
		it.goal_row = 5'(gr);
		it.path_index = 10'(pidx);
		return it;
	endfunction

	// Coordinate inside the map most of the time; near the origin on the full grid
	function automatic int pick_coord(int lim);
		if ($urandom_range(0, 9) == 0 || lim == 0) return $urandom_range(0, 31);
		if (big_map) return $urandom_range(0, 9);
		return $urandom_range(0, lim - 1);
	endfunction

	function automatic int pick_tile();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return BLOCKED_TILE_CODE;
			default: return $urandom_range(1, 254);
		endcase
	endfunction

	task automatic run_phase(int w, int h, int count, int search_pct);
		int ew, eh, r;
		in_item_t it;
		drain();
		write_reg(REG_MAP_WIDTH, w);
		write_reg(REG_MAP_HEIGHT, h);
		ew = sb.eff_w();
		eh = sb.eff_h();
		big_map = ew * eh > 64;
		tx_busy = $urandom_range(0, 3) != 0;
		rx_busy = $urandom_range(0, 3) != 0;
		// lay out the small map first so searches have terrain to cross
		if (!big_map) begin
			for (int y = 0; y < eh; y++)
				for (int x = 0; x < ew; x++)
					send_item(make_item(OP_WRITE, x, y,
						$urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 254), 0, 0, 0));
		end
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 2)
				it = make_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom);
			else if (r < 2 + search_pct)
				it = make_item(OP_SEARCH, pick_coord(ew), pick_coord(eh), $urandom,
					pick_coord(ew), pick_coord(eh), $urandom);
			else if (r < 55)
				it = make_item(OP_WRITE, pick_coord(ew), pick_coord(eh), pick_tile(), $urandom,
					$urandom, $urandom);
			else
				it = make_item(OP_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom_range(0, 9) == 0 ? $urandom_range(0, 1023)
						: $urandom_range(0, sb.stored_len + 1));
			send_item(it);
		end
	endtask

	initial begin
		sb = new();
		tx_busy = 1;
		rx_busy = 1;
		long_hold = 0;
		big_map = 1;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty grid, tile codes, trivial and short paths, unreachable goal
		send_item(make_item(OP_READ, 0, 0, 0, 0, 0, 0));
		send_item(make_item(OP_SEARCH, 0, 0, 0, 0, 0, 0));
		send_item(make_item(OP_WRITE, 0, 0, BLOCKED_TILE_CODE, 0, 0, 0));
		send_item(make_item(OP_SEARCH, 0, 0, 0, 0, 0, 0));
		send_item(make_item(OP_WRITE, 0, 0, 8'h80, 0, 0, 0));
		send_item(make_item(OP_WRITE, 1, 0, 8'h01, 0, 0, 0));
		send_item(make_item(OP_WRITE, 1, 1, 8'hFE, 0, 0, 0));
		send_item(make_item(OP_WRITE, 2, 1, 8'h7F, 0, 0, 0));
		send_item(make_item(OP_WRITE, 31, 31, 8'h01, 0, 0, 0));
		send_item(make_item(OP_SEARCH, 0, 0, 0, 0, 0, 0));
		send_item(make_item(OP_READ, 0, 0, 0, 0, 0, 0));
		send_item(make_item(OP_READ, 0, 0, 0, 0, 0, 1));
		send_item(make_item(OP_SEARCH, 0, 0, 0, 2, 1, 0));
		for (int i = 0; i < 4; i++) send_item(make_item(OP_READ, 0, 0, 0, 0, 0, i));
		send_item(make_item(OP_UNUSED, 31, 31, 8'hFF, 31, 31, 10'h3FF));
		send_item(make_item(OP_READ, 0, 0, 0, 0, 0, 1023));
		send_item(make_item(OP_SEARCH, 0, 0, 0, 31, 31, 0));
		send_item(make_item(OP_SEARCH, 2, 1, 0, 5, 5, 0));
		send_item(make_item(OP_WRITE, 1, 0, 8'h00, 0, 0, 0));
		send_item(make_item(OP_SEARCH, 2, 1, 0, 0, 0, 0));
		send_item(make_item(OP_READ, 0, 0, 0, 0, 0, 2));

		// random phases; the receiver holds off once while items keep coming
		run_phase(6, 6, 120, 20);
		long_hold = 1;
		run_phase(3, 3, 150, 20);
		run_phase(0, 5, 60, 20);
		run_phase(8, 8, 120, 20);
		run_phase(1, 8, 120, 20);
		run_phase(8, 1, 120, 20);
		run_phase(2, 2, 120, 20);
		run_phase(5, 0, 50, 20);
		run_phase(5, 7, 120, 20);
		run_phase(32, 32, 150, 4);
		run_phase(8, 4, 90, 20);
		run_phase(63, 33, 110, 4);

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("grid_astar_path_search_core_tb: done, clean");
		else
			$display("grid_astar_path_search_core_tb: done, errors");
		$finish;
	end

endmodule
